// ===== rtl/core/fspp_pkg.sv =====
// Shared types and constants for the flow size priority predictor.
package fspp_pkg;

    localparam int PRED_W = 40;
    localparam logic [PRED_W-1:0] PRED_MAX = {PRED_W{1'b1}};
    localparam logic [15:0] MIN_SEG_RESET = 16'd1460;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [15:0] probability;
        logic [31:0] center;
        logic [31:0] seq;
    } t_req;

    typedef struct packed {
        logic [31:0] priority_res;
        logic        table_full;
    } t_res;

    typedef struct packed {
        logic [15:0] prob;
        logic [31:0] center;
    } t_bucket;

endpackage

// ===== rtl/core/fspp_bucket_ram.sv =====
// Bucket table memory: one write port, one read port with registered data.
module fspp_bucket_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  fspp_pkg::t_bucket   i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output fspp_pkg::t_bucket   o_rdata
);
    import fspp_pkg::*;

    t_bucket r_mem [DEPTH];
    t_bucket r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/flow_size_priority_predictor_top.sv =====
// Top level of the flow size priority predictor: sequencer, prediction and result logic.
//
//   Channel   Direction  Ports                          Handshake
//   request   in         start, i_req (t_req)           taken when start & !busy
//   result    out        o_done, o_res (t_res)          one-cycle strobe, no back-pressure
//   config    in         i_cfg_we, i_cfg_wdata          written when i_cfg_we is high
//
// Clear and load requests are answered in the cycle after they are taken and busy stays low.
// A start runs one refinement; on an empty table it only grows the prediction. A query is
// answered as soon as the prediction reaches the target, with a refinement pass run each
// time it falls short. Each refinement walks the bucket table twice through its single read
// port (argmax pass, then compaction pass), so table occupancy sets how long it runs.
// Reset (i_rst_n low, synchronous) empties the table, zeroes the prediction and sets
// min_segment to 1460. The receiver cannot stall; a result is shown for one cycle only.
module flow_size_priority_predictor_top #(
    parameter int ENTRIES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fspp_pkg::t_req i_req,
    output logic           o_done,
    output fspp_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata
);
    import fspp_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    // Sequencer states. REFINE sets up a refinement, AMAX finds the most probable
    // entry, CPT drops covered entries while tracking the smallest survivor, UPDATE
    // forms the new prediction and CHECK answers a start or decides whether a query is answered.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REFINE = 6'b000010,
        S_AMAX   = 6'b000100,
        S_CPT    = 6'b001000,
        S_UPDATE = 6'b010000,
        S_CHECK  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [PRED_W-1:0] r_pred, n_pred;
    logic [15:0]     r_min_seg;
    logic            r_is_query, n_is_query;
    logic [32:0]     r_target, n_target;
    logic [CW-1:0]   r_addr, n_addr;
    logic            r_rv, n_rv;
    logic            r_rlast, n_rlast;
    logic            r_first, n_first;
    logic [15:0]     r_best_prob, n_best_prob;
    logic [31:0]     r_chosen, n_chosen;
    logic [CW-1:0]   r_kept, n_kept;
    logic            r_any, n_any;
    logic [31:0]     r_smallest, n_smallest;
    logic            r_done, n_done;
    t_res            r_res, n_res;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    t_bucket         mem_wdata;
    logic [IW-1:0]   mem_raddr;
    t_bucket         mem_rdata;
    logic            issue;

    logic [PRED_W+1:0] grow_sum;
    logic [PRED_W-1:0] grow_val;
    logic [PRED_W-1:0] upd_val;
    logic [PRED_W-1:0] target_ext;
    logic [PRED_W-1:0] diff;
    logic [PRED_W-2:0] diff_half;

    // Raise a prediction to the floor of twice the segment size.
    function automatic logic [PRED_W-1:0] f_floor(input logic [PRED_W-1:0] p,
                                                  input logic [15:0] ms);
        logic [PRED_W-1:0] fl;
        fl = {{(PRED_W-17){1'b0}}, ms, 1'b0};
        return (p < fl) ? fl : p;
    endfunction

    fspp_bucket_ram #(
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The read pointer walks the valid entries; data comes back in the next cycle
    // together with r_rv and r_rlast.
    assign issue     = (r_addr < r_count);
    assign mem_raddr = issue ? r_addr[IW-1:0] : '0;

    // Empty-table growth: 2P + 4, saturated to the 40-bit range.
    assign grow_sum = {1'b0, r_pred, 1'b0} + (PRED_W+2)'(4);
    assign grow_val = (grow_sum[PRED_W+1:PRED_W] != 2'b00) ? PRED_MAX
                                                           : grow_sum[PRED_W-1:0];

    // Midpoint stored as c + s, or 2c when nothing survives.
    assign upd_val = r_any ? {{(PRED_W-33){1'b0}}, {1'b0, r_chosen} + {1'b0, r_smallest}}
                           : {{(PRED_W-33){1'b0}}, r_chosen, 1'b0};

    assign target_ext = {{(PRED_W-33){1'b0}}, r_target};
    assign diff       = r_pred - target_ext;
    assign diff_half  = diff[PRED_W-1:1];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pred      = r_pred;
        n_is_query  = r_is_query;
        n_target    = r_target;
        n_addr      = r_addr;
        n_rv        = 1'b0;
        n_rlast     = 1'b0;
        n_first     = r_first;
        n_best_prob = r_best_prob;
        n_chosen    = r_chosen;
        n_kept      = r_kept;
        n_any       = r_any;
        n_smallest  = r_smallest;
        n_done      = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = r_count[IW-1:0];
        mem_wdata   = '{prob: i_req.probability, center: i_req.center};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_is_query = 1'b0;
                    case (i_req.command)
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_pred  = '0;
                            n_res   = '0;
                            n_done  = 1'b1;
                        end
                        CMD_LOAD: begin
                            n_res  = '0;
                            n_done = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_res.table_full = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_START: begin
                            n_state = S_REFINE;
                        end
                        CMD_QUERY: begin
                            n_is_query = 1'b1;
                            n_target   = {i_req.seq, 1'b0};
                            n_state    = S_CHECK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_REFINE: begin
                if (r_count == '0) begin
                    n_pred  = f_floor(grow_val, r_min_seg);
                    n_state = S_CHECK;
                end else begin
                    n_addr  = '0;
                    n_first = 1'b1;
                    n_state = S_AMAX;
                end
            end
            S_AMAX: begin
                n_rv    = issue;
                n_rlast = (r_addr == r_count - 1'b1);
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_rv) begin
                    // Strict compare keeps the earliest entry on ties.
                    if (r_first || (mem_rdata.prob > r_best_prob)) begin
                        n_best_prob = mem_rdata.prob;
                        n_chosen    = mem_rdata.center;
                    end
                    n_first = 1'b0;
                    if (r_rlast) begin
                        n_addr  = '0;
                        n_rv    = 1'b0;
                        n_kept  = '0;
                        n_any   = 1'b0;
                        n_state = S_CPT;
                    end
                end
            end
            S_CPT: begin
                n_rv    = issue;
                n_rlast = (r_addr == r_count - 1'b1);
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_rv) begin
                    // Survivors are packed down to the write slot, which always
                    // trails the read pointer.
                    if (mem_rdata.center > r_chosen) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_kept[IW-1:0];
                        mem_wdata = mem_rdata;
                        n_kept    = r_kept + 1'b1;
                        if (!r_any || (mem_rdata.center < r_smallest)) begin
                            n_smallest = mem_rdata.center;
                        end
                        n_any = 1'b1;
                    end
                    if (r_rlast) begin
                        n_rv    = 1'b0;
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                n_count = r_kept;
                n_pred  = f_floor(upd_val, r_min_seg);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_is_query) begin
                    n_res   = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_pred >= target_ext) begin
                    n_res = '0;
                    if (diff_half == '0) begin
                        n_res.priority_res = 32'd1;
                    end else if (diff_half[PRED_W-2:32] != '0) begin
                        n_res.priority_res = 32'hFFFF_FFFF;
                    end else begin
                        n_res.priority_res = diff_half[31:0];
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_REFINE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pred     <= '0;
            r_min_seg  <= MIN_SEG_RESET;
            r_is_query <= 1'b0;
            r_addr     <= '0;
            r_rv       <= 1'b0;
            r_rlast    <= 1'b0;
            r_first    <= 1'b0;
            r_kept     <= '0;
            r_any      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pred     <= n_pred;
            r_is_query <= n_is_query;
            r_addr     <= n_addr;
            r_rv       <= n_rv;
            r_rlast    <= n_rlast;
            r_first    <= n_first;
            r_kept     <= n_kept;
            r_any      <= n_any;
            r_done     <= n_done;
            if (i_cfg_we) begin
                r_min_seg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_target    <= n_target;
        r_best_prob <= n_best_prob;
        r_chosen    <= n_chosen;
        r_smallest  <= n_smallest;
        r_res       <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    // A result only appears once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Clear and load answer on the very next cycle.
    a_fast_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.command == CMD_CLEAR || i_req.command == CMD_LOAD))
        |=> o_done)
        else $error("clear or load without a result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond table depth");

    // Compaction must never write ahead of the read pointer.
    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CPT) |-> (r_kept <= r_addr))
        else $error("compaction write slot passed read pointer");

    a_query_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_is_query) |-> (o_res.priority_res != '0 && !o_res.table_full))
        else $error("query result out of range");

endmodule
